// ===== hdl/usb_iso_out_endpoint_finder_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the isochronous OUT endpoint finder
// Same-cycle and next-cycle implication checks on clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef USB_ISO_OUT_ENDPOINT_FINDER_DEFINES_SVH
`define USB_ISO_OUT_ENDPOINT_FINDER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define USBEP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("usbep: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define USBEP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("usbep: next-cycle check failed");

`endif

// ===== hdl/usbep_pkg.sv =====
// ---------------------------------------------------------------------------
// usbep_pkg
// Transfer types, register indexes and descriptor codes for the endpoint finder.
// ---------------------------------------------------------------------------
`default_nettype none

package usbep_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } in_t;

    typedef struct packed {
        logic        found;
        logic [6:0]  endpoint_address;
        logic [15:0] max_packet;
        logic [7:0]  poll_interval;
    } out_t;

    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_INTERFACE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ALT       = 1'b1;

    localparam logic [7:0] DESC_TYPE_INTERFACE = 8'd4;
    localparam logic [7:0] DESC_TYPE_ENDPOINT  = 8'd5;
    localparam logic [7:0] IFACE_MIN_LEN       = 8'd9;
    localparam logic [7:0] EP_MIN_LEN          = 8'd7;
    localparam logic [7:0] DESC_MIN_LEN        = 8'd2;
    localparam logic [1:0] XFER_ISOCHRONOUS    = 2'b01;

endpackage

`default_nettype wire

// ===== hdl/usbep_parse.sv =====
// ---------------------------------------------------------------------------
// usbep_parse
// Descriptor walker: tracks position in each descriptor and latches the match.
// ---------------------------------------------------------------------------
`default_nettype none

module usbep_parse (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           fire,
    input  wire usbep_pkg::in_t                 in_data,
    input  wire logic                           cfg_we,
    input  wire logic [usbep_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                     cfg_data,
    output logic                                res_valid,
    output usbep_pkg::out_t                     res
);

    logic [7:0]  target_if_reg;
    logic [7:0]  target_alt_reg;

    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  type_reg, type_next;
    logic [39:0] cap_reg, cap_next;
    logic        in_target_reg, in_target_next;
    logic        halted_reg, halted_next;
    logic        latched_reg, latched_next;
    logic [6:0]  addr_reg, addr_next;
    logic [15:0] mps_reg, mps_next;
    logic [7:0]  ival_reg, ival_next;

    logic [7:0]  b;
    logic [7:0]  type_work;
    logic [39:0] cap_work;
    logic        desc_done;

    assign b = in_data.data_byte;

    always_comb
    begin
        pos_next       = pos_reg;
        len_next       = len_reg;
        type_next      = type_reg;
        cap_next       = cap_reg;
        in_target_next = in_target_reg;
        halted_next    = halted_reg;
        latched_next   = latched_reg;
        addr_next      = addr_reg;
        mps_next       = mps_reg;
        ival_next      = ival_reg;

        type_work = (pos_reg == 8'd1) ? b : type_reg;
        cap_work  = cap_reg;
        for (int i = 0; i < 5; i++)
        begin
            if (pos_reg == 8'(i + 2))
                cap_work[8*i +: 8] = cap_reg[8*i +: 8] | b;
        end
        desc_done = ({1'b0, pos_reg} + 9'd1) >= {1'b0, len_reg};

        if (fire && !halted_reg)
        begin
            if (pos_reg == 8'd0)
            begin
                // length byte: too short stops the walk
                if (b < usbep_pkg::DESC_MIN_LEN)
                begin
                    halted_next = 1'b1;
                end
                else
                begin
                    len_next = b;
                    cap_next = '0;
                    pos_next = 8'd1;
                end
            end
            else
            begin
                type_next = type_work;
                cap_next  = cap_work;
                if (desc_done)
                begin
                    pos_next = 8'd0;
                    if (type_work == usbep_pkg::DESC_TYPE_INTERFACE &&
                        len_reg >= usbep_pkg::IFACE_MIN_LEN)
                    begin
                        in_target_next = (cap_work[7:0] == target_if_reg) &&
                                         (cap_work[15:8] == target_alt_reg);
                    end
                    else if (in_target_reg &&
                             type_work == usbep_pkg::DESC_TYPE_ENDPOINT &&
                             len_reg >= usbep_pkg::EP_MIN_LEN)
                    begin
                        if (cap_work[9:8] == usbep_pkg::XFER_ISOCHRONOUS &&
                            !cap_work[7] && !latched_reg)
                        begin
                            latched_next = 1'b1;
                            addr_next    = cap_work[6:0];
                            mps_next     = cap_work[31:16];
                            ival_next    = cap_work[39:32];
                        end
                    end
                end
                else
                begin
                    pos_next = pos_reg + 8'd1;
                end
            end
        end

        res_valid            = fire && in_data.last;
        res.found            = latched_next;
        res.endpoint_address = latched_next ? addr_next : 7'd0;
        res.max_packet       = latched_next ? mps_next : 16'd0;
        res.poll_interval    = latched_next ? ival_next : 8'd0;

        // end of blob: report, then start afresh
        if (res_valid)
        begin
            pos_next       = '0;
            len_next       = '0;
            type_next      = '0;
            cap_next       = '0;
            in_target_next = 1'b0;
            halted_next    = 1'b0;
            latched_next   = 1'b0;
            addr_next      = '0;
            mps_next       = '0;
            ival_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_if_reg  <= '0;
            target_alt_reg <= '0;
            pos_reg        <= '0;
            len_reg        <= '0;
            type_reg       <= '0;
            cap_reg        <= '0;
            in_target_reg  <= 1'b0;
            halted_reg     <= 1'b0;
            latched_reg    <= 1'b0;
            addr_reg       <= '0;
            mps_reg        <= '0;
            ival_reg       <= '0;
        end
        else
        begin
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            type_reg      <= type_next;
            cap_reg       <= cap_next;
            in_target_reg <= in_target_next;
            halted_reg    <= halted_next;
            latched_reg   <= latched_next;
            addr_reg      <= addr_next;
            mps_reg       <= mps_next;
            ival_reg      <= ival_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    usbep_pkg::CFG_TARGET_INTERFACE: target_if_reg  <= cfg_data;
                    usbep_pkg::CFG_TARGET_ALT:       target_alt_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/usb_iso_out_endpoint_finder.sv =====
// ---------------------------------------------------------------------------
// usb_iso_out_endpoint_finder
// Finds the isochronous OUT endpoint of a chosen interface and alternate
// setting in a streamed configuration descriptor.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries the descriptor blob
//   one byte per transfer; in_data.last marks its final byte. One byte is
//   taken every cycle while in_stall is low: the descriptor walk is a single
//   counter/compare update between the walker's state registers.
//   Output channel (out_valid / out_stall / out_data) gives one result per
//   blob, registered after the final byte is taken.
//   Configuration: cfg_we with cfg_index selects target interface (0) or
//   target alternate setting (1); cfg_data is the value. Write while idle.
//   When the receiver stalls, the result holds and a second result goes to a
//   skid register; in_stall rises only once that register is full, so input
//   keeps flowing until two results are pending.
//   Reset clears the walk, the latched endpoint, both targets and the output.
// ---------------------------------------------------------------------------
`default_nettype none
`include "usb_iso_out_endpoint_finder_defines.svh"

module usb_iso_out_endpoint_finder (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire usbep_pkg::in_t                  in_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output usbep_pkg::out_t                      out_data,
    input  wire logic                            cfg_we,
    input  wire logic [usbep_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                      cfg_data
);

    logic            fire;
    logic            res_valid;
    usbep_pkg::out_t res;

    logic            out_valid_reg;
    usbep_pkg::out_t out_data_reg;
    logic            skid_valid_reg;
    usbep_pkg::out_t skid_data_reg;

    assign in_stall  = skid_valid_reg;
    assign fire      = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    usbep_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            // output register free: drain skid first
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res;
        end
        else if (res_valid)
        begin
            skid_data_reg <= res;
        end
    end

    `USBEP_ASSERT_IMPL(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `USBEP_ASSERT_IMPL(a_no_lost_result, res_valid, !skid_valid_reg)
    `USBEP_ASSERT_IMPL(a_empty_result_zero, out_valid_reg && !out_data_reg.found,
        out_data_reg.endpoint_address == 7'd0 && out_data_reg.max_packet == 16'd0 &&
        out_data_reg.poll_interval == 8'd0)
    `USBEP_ASSERT_NEXT(a_skid_drains, skid_valid_reg && !out_stall, !skid_valid_reg)

endmodule

`default_nettype wire
